>>> rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and constants for the streaming base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 24;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Number of '=' pads a group ends with
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } pad_kind_t;

    // One group handed from the front end to the character serialiser
    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        pad_kind_t          pads;
        logic               last;
    } group_t;

    // Six-bit value to standard alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62) begin
            c = 8'h2B;
        end
        else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Collects message bytes into 24-bit groups and classifies each finished
// group by its pad count and end-of-message flag.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_eom,
    input  wire logic            queue_full,
    output logic                 in_ready,
    output logic                 push,
    output b64e_pkg::group_t     push_group
);
    import b64e_pkg::*;

    logic [7:0] byte0_reg;
    logic [7:0] byte1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Group assembly and classification
    always_comb
    begin
        count_next       = count_reg;
        push             = 1'b0;
        push_group.bits  = {byte0_reg, byte1_reg, in_byte};
        push_group.pads  = PAD_NONE;
        push_group.last  = in_eom;
        if (accept) begin
            if (count_reg == 2'd2) begin
                push       = 1'b1;
                count_next = 2'd0;
            end
            else if (!in_eom) begin
                count_next = count_reg + 2'd1;
            end
            else if (count_reg == 2'd0) begin
                push            = 1'b1;
                push_group.bits = {in_byte, 16'h0000};
                push_group.pads = PAD_TWO;
                count_next      = 2'd0;
            end
            else begin
                push            = 1'b1;
                push_group.bits = {byte0_reg, in_byte, 8'h00};
                push_group.pads = PAD_ONE;
                count_next      = 2'd0;
            end
        end
    end

    // Pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    // Pending bytes, written only when a byte is held over
    always_ff @(posedge clk)
    begin
        if (accept && !in_eom && count_reg == 2'd0) begin
            byte0_reg <= in_byte;
        end
        if (accept && !in_eom && count_reg == 2'd1) begin
            byte1_reg <= in_byte;
        end
    end

    // Count only ever walks 0, 1, 2
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("pending count out of range");

endmodule

`default_nettype wire

>>> rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small register FIFO of classified groups between front end and serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire b64e_pkg::group_t push_group,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output b64e_pkg::group_t     head
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    group_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("group pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("group popped from empty queue");

endmodule

`default_nettype wire

>>> rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Serialises one group into four characters, one per cycle while the output
// is not stalled by out_ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            grp_valid,
    input  wire b64e_pkg::group_t grp,
    output logic                 grp_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_char,
    output logic                 out_last
);
    import b64e_pkg::*;

    group_t     group_reg;
    logic       active_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    logic       out_load;
    logic       advance;
    logic       group_done;
    logic [5:0] sextet;
    logic       is_pad;
    logic [7:0] char_next;

    assign out_load   = !valid_reg || out_ready;
    assign advance    = out_load && active_reg;
    assign group_done = advance && (idx_reg == 2'd3);
    assign grp_pop    = (!active_reg || group_done) && grp_valid;

    // Character for the current index
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = group_reg.bits[23:18];
            2'd1:    sextet = group_reg.bits[17:12];
            2'd2:    sextet = group_reg.bits[11:6];
            default: sextet = group_reg.bits[5:0];
        endcase
        unique case (group_reg.pads)
            PAD_TWO: is_pad = idx_reg[1];
            PAD_ONE: is_pad = (idx_reg == 2'd3);
            default: is_pad = 1'b0;
        endcase
        char_next = is_pad ? PAD_CHAR : b64_char(sextet);
    end

    // Control: group occupancy, index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            idx_reg    <= 2'd0;
            valid_reg  <= 1'b0;
        end
        else begin
            if (out_load) begin
                valid_reg <= active_reg;
            end
            if (grp_pop) begin
                active_reg <= 1'b1;
                idx_reg    <= 2'd0;
            end
            else if (group_done) begin
                active_reg <= 1'b0;
            end
            else if (advance) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (grp_pop) begin
            group_reg <= grp;
        end
        if (advance) begin
            char_reg <= char_next;
            last_reg <= group_reg.last && (idx_reg == 2'd3);
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    // A pad that is not the final character is directly followed by another
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && char_reg == PAD_CHAR && !last_reg)
        |=> (valid_reg && char_reg == PAD_CHAR && last_reg))
        else $error("broken pad sequence");

    // Last flag only ever on the fourth character of a group
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_reg != 2'd3) |=> !last_reg)
        else $error("last flag set mid-group");

endmodule

`default_nettype wire

>>> rtl/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming base64 encoder, standard alphabet, no line breaks.
// ----------------------------------------------------------------------------
// One message byte is taken per transfer on the slave side, tlast marking the
// final byte of a message. Every third byte, or the final byte, completes a
// group, which becomes four characters on the master side, one per cycle
// while m_tready is high, with '=' padding for a short final group and tlast
// on the final character. A byte is taken in every cycle while the group
// queue has room; output is limited to one character per cycle by the
// serialiser. From the completing byte, a group passes through the queue
// entry, the serialiser's group register and the registered output stage
// before its first character appears. QUEUE_DEPTH sets how many groups may
// wait between the two sides.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_message
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tlast    // last_char
);
    import b64e_pkg::*;

    logic   push;
    group_t push_group;
    logic   queue_full;
    logic   queue_not_empty;
    group_t queue_head;
    logic   pop;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_eom     (s_tlast),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_group (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (queue_head)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .grp_valid  (queue_not_empty),
        .grp        (queue_head),
        .grp_pop    (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

>>> dv/base64_stream_encoder_core_checker.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core_checker
// Watches both stream channels of the base64 encoder, predicts the encoded
// character stream from every byte transfer and compares each character
// transfer, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_message
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_char
    input  logic       m_tlast,   // last_char
    output int         mismatches,
    output int         chars_left
);
    timeunit 1ns;
    timeprecision 1ps;

    // Standard alphabet, first character in the top byte
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } enc_char_t;

    enc_char_t  chars_due[$];
    logic [7:0] held_bytes [2];
    logic [1:0] held_count;

    initial begin
        mismatches = 0;
        chars_left = 0;
        held_count = 2'd0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
    end

    // Character for the six bits of a group starting at bit 'lsb'
    function automatic logic [7:0] sextet_char(input logic [23:0] grp, input int lsb);
        logic [5:0] v;
        v = grp[lsb +: 6];
        return ALPHABET[(63 - int'(v)) * 8 +: 8];
    endfunction

    function automatic enc_char_t mk_char(input logic [7:0] code, input logic last);
        enc_char_t c;
        c.code = code;
        c.last = last;
        return c;
    endfunction

    // Prediction for one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [23:0] grp;
        if (held_count == 2'd2) begin
            // third byte closes the group
            grp = {held_bytes[0], held_bytes[1], b};
            chars_due.push_back(mk_char(sextet_char(grp, 18), 1'b0));
            chars_due.push_back(mk_char(sextet_char(grp, 12), 1'b0));
            chars_due.push_back(mk_char(sextet_char(grp, 6), 1'b0));
            chars_due.push_back(mk_char(sextet_char(grp, 0), eom));
            held_count = 2'd0;
        end
        else if (!eom) begin
            held_bytes[held_count] = b;
            held_count = held_count + 2'd1;
        end
        else if (held_count == 2'd0) begin
            // single byte left over: two pads
            grp = {b, 16'h0000};
            chars_due.push_back(mk_char(sextet_char(grp, 18), 1'b0));
            chars_due.push_back(mk_char(sextet_char(grp, 12), 1'b0));
            chars_due.push_back(mk_char(b64e_pkg::PAD_CHAR, 1'b0));
            chars_due.push_back(mk_char(b64e_pkg::PAD_CHAR, 1'b1));
            held_count = 2'd0;
        end
        else begin
            // two bytes left over: one pad
            grp = {held_bytes[0], b, 8'h00};
            chars_due.push_back(mk_char(sextet_char(grp, 18), 1'b0));
            chars_due.push_back(mk_char(sextet_char(grp, 12), 1'b0));
            chars_due.push_back(mk_char(sextet_char(grp, 6), 1'b0));
            chars_due.push_back(mk_char(b64e_pkg::PAD_CHAR, 1'b1));
            held_count = 2'd0;
        end
    endtask

    // One line per mismatch, every one counted
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_char(input logic [7:0] code, input logic last);
        enc_char_t want;
        if (chars_due.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%b", code, last));
        end
        else begin
            want = chars_due.pop_front();
            if (code !== want.code)
                report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                          code, want.code));
            if (last !== want.last)
                report_mismatch($sformatf("last_char %b, expected %b", last, want.last));
        end
    endtask

    // Sample both channels on the rising edge; byte side first
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_count = 2'd0;
            chars_due.delete();
            chars_left = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_char(m_tdata, m_tlast);
            chars_left = chars_due.size();
        end
    end

endmodule

>>> dv/base64_stream_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core_tb
// Drives byte messages into the base64 encoder with random idle gaps on the
// byte side and random stalls on the character side. A directed set covers
// the alphabet extremes and every padding case, then random messages of
// mixed length follow. The checker instance judges every character.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int RANDOM_BYTES = 320;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 16;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic       s_tlast;   // end_of_message
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_char
    logic       m_tlast;   // last_char

    int mismatches;
    int chars_left;
    int cycle_count = 0;
    bit tx_steady   = 1'b0;

    base64_stream_encoder_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    base64_stream_encoder_core_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .chars_left (chars_left)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base64_stream_encoder_core_tb: FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Character side back-pressure, with stall-free stretches
    initial begin : char_sink
        int stall_left;
        int steady_left;
        stall_left  = 0;
        steady_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else begin
                m_tready <= 1'b1;
                if (steady_left > 0)
                    steady_left--;
                else if ($urandom_range(0, 99) < 5)
                    steady_left = $urandom_range(20, 150);
                else if ($urandom_range(0, 99) < 30)
                    stall_left = gap_len();
            end
        end
    end

    // One byte transfer; called and returns on a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the byte side off until every predicted character has left
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (chars_left != 0) @(negedge clk);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int sent;
        int len;
        int r;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        sent     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: full group on the final byte
        tx_steady = 1'b1;
        send_byte("M", 1'b0);
        send_byte("a", 1'b0);
        send_byte("n", 1'b1);
        // one byte left over, then two bytes left over
        send_byte("M", 1'b1);
        send_byte("M", 1'b0);
        send_byte("a", 1'b1);
        // all-zero and all-one groups, group completing mid-message
        tx_steady = 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // all-ones short groups
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // four '+' then a padded tail
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'h00, 1'b1);
        hold_until_drained();

        // Random messages of mixed length
        while (sent < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(1, 6);
            else if (r < 90)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(21, 40);
            tx_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
            sent += len;
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        // Wind down
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (chars_left != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("base64_stream_encoder_core_tb: PASS");
        else
            $display("base64_stream_encoder_core_tb: FAIL");
        $finish;
    end

endmodule
